### hdl/ohi_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturating helpers for the orbit Hermite interpolator.
// No dependencies.
package ohi_pkg;

    typedef logic signed [63:0] q64_t;

    typedef enum logic [1:0] {
        SH23 = 2'd0,
        SH24 = 2'd1,
        SH31 = 2'd2,
        SH32 = 2'd3
    } shift_t;

    localparam int TIME_W      = 48;
    localparam int POS_W       = 56;
    localparam int VEL_W       = 48;
    localparam int IN_TDATA_W  = 368;
    localparam int OUT_TDATA_W = 312;
    localparam int MAX_AXES    = 3;

    localparam q64_t ONE_Q32 = 64'sh0000_0001_0000_0000;
    localparam q64_t Q64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q64_t Q64_MIN = 64'sh8000_0000_0000_0000;

    function automatic logic [5:0] shift_amt(input shift_t sh);
        logic [5:0] r;
        begin
            case (sh)
                SH23:    r = 6'd23;
                SH24:    r = 6'd24;
                SH31:    r = 6'd31;
                default: r = 6'd32;
            endcase
            shift_amt = r;
        end
    endfunction

    function automatic logic [63:0] mag64(input q64_t a);
        begin
            mag64 = a[63] ? (64'd0 - 64'(a)) : 64'(a);
        end
    endfunction

    function automatic q64_t from_mag(input logic neg, input logic [63:0] mag);
        q64_t r;
        begin
            if (!neg)
                r = mag[63] ? Q64_MAX : q64_t'(mag);
            else
                r = mag[63] ? Q64_MIN : q64_t'(64'd0 - mag);
            from_mag = r;
        end
    endfunction

    function automatic q64_t sat_add(input q64_t a, input q64_t b);
        logic signed [64:0] s;
        begin
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
                sat_add = s[64] ? Q64_MIN : Q64_MAX;
            else
                sat_add = s[63:0];
        end
    endfunction

    function automatic q64_t sat_sub(input q64_t a, input q64_t b);
        logic signed [64:0] s;
        begin
            s = {a[63], a} - {b[63], b};
            if (s[64] != s[63])
                sat_sub = s[64] ? Q64_MIN : Q64_MAX;
            else
                sat_sub = s[63:0];
        end
    endfunction

    function automatic logic signed [55:0] clamp_pos(input q64_t v);
        begin
            if (v[63:55] != {9{v[63]}})
                clamp_pos = v[63] ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}};
            else
                clamp_pos = v[55:0];
        end
    endfunction

    function automatic logic signed [47:0] clamp_vel(input q64_t v);
        begin
            if (v[63:47] != {17{v[63]}})
                clamp_vel = v[63] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            else
                clamp_vel = v[47:0];
        end
    endfunction

endpackage

### hdl/ohi_mul.sv
`timescale 1ns / 1ps
// Bit-serial signed multiply with rounded right shift and 64-bit saturation.
// Depends on ohi_pkg.
module ohi_mul
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ohi_pkg::q64_t        a,
    input  ohi_pkg::q64_t        b,
    input  ohi_pkg::shift_t      sh,
    output logic                 done,
    output ohi_pkg::q64_t        y
);

    logic            busy_reg, busy_next;
    logic            fin_reg, fin_next;
    logic            done_reg, done_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic            neg_reg;
    logic [63:0]     mx_reg, my_reg;
    logic [127:0]    acc_reg;
    ohi_pkg::shift_t sh_reg;
    ohi_pkg::q64_t   y_reg;

    logic [64:0]     psum;
    logic [5:0]      sa;
    logic [127:0]    p2;
    logic [127:0]    shifted;
    logic [63:0]     mag;

    always_comb
    begin
        psum    = {1'b0, acc_reg[127:64]} + (my_reg[0] ? {1'b0, mx_reg} : 65'd0);
        sa      = ohi_pkg::shift_amt(sh_reg);
        p2      = acc_reg + (128'd1 << (sa - 6'd1));
        shifted = p2 >> sa;
        mag     = (|shifted[127:64]) ? {64{1'b1}} : shifted[63:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = fin_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= a[63] ^ b[63];
            mx_reg  <= ohi_pkg::mag64(a);
            my_reg  <= ohi_pkg::mag64(b);
            acc_reg <= '0;
            sh_reg  <= sh;
        end
        else if (busy_reg)
        begin
            acc_reg <= {psum, acc_reg[63:1]};
            my_reg  <= {1'b0, my_reg[63:1]};
        end
        if (fin_reg)
            y_reg <= ohi_pkg::from_mag(neg_reg, mag);
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

### hdl/ohi_div.sv
`timescale 1ns / 1ps
// Restoring bit-serial divider: round(num * 2^32 / den), half away from zero, saturated.
// Depends on ohi_pkg.
module ohi_div
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ohi_pkg::q64_t num,
    input  ohi_pkg::q64_t den,
    output logic          done,
    output ohi_pkg::q64_t y
);

    localparam int NUM_BITS = 97;

    logic          busy_reg, busy_next;
    logic          fin_reg, fin_next;
    logic          done_reg, done_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic          neg_reg, bad_reg, ovf_reg;
    logic [63:0]   ud_reg, r_reg, q_reg;
    logic [NUM_BITS-1:0] n_reg;
    ohi_pkg::q64_t y_reg;

    logic [63:0]   ud_in;
    logic          bad_in;
    logic [63:0]   rs;
    logic          ge;
    logic [63:0]   rnd;

    always_comb
    begin
        ud_in  = ohi_pkg::mag64(den);
        bad_in = (ud_in == 64'd0) || (ud_in[63:62] != 2'b00);
        rs     = {r_reg[62:0], n_reg[NUM_BITS-1]};
        ge     = (rs >= ud_reg);
        rnd    = {1'b0, q_reg[63:1]} + {63'd0, q_reg[0]};
    end

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = fin_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            cnt_next = '0;
            if (bad_in)
                fin_next = 1'b1;
            else
                busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(NUM_BITS - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[63] ^ den[63];
            bad_reg <= bad_in;
            ovf_reg <= 1'b0;
            ud_reg  <= ud_in;
            r_reg   <= '0;
            q_reg   <= '0;
            n_reg   <= {ohi_pkg::mag64(num), 33'd0};
        end
        else if (busy_reg)
        begin
            r_reg   <= ge ? (rs - ud_reg) : rs;
            q_reg   <= {q_reg[62:0], ge};
            ovf_reg <= ovf_reg | q_reg[63];
            n_reg   <= {n_reg[NUM_BITS-2:0], 1'b0};
        end
        if (fin_reg)
        begin
            if (bad_reg)
                y_reg <= '0;
            else if (ovf_reg)
                y_reg <= neg_reg ? ohi_pkg::Q64_MIN : ohi_pkg::Q64_MAX;
            else
                y_reg <= ohi_pkg::from_mag(neg_reg, rnd);
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

### hdl/ohi_lane.sv
`timescale 1ns / 1ps
// One interpolation lane: basis, weights and per-axis terms for a single node.
// Depends on ohi_pkg, ohi_mul and ohi_div.
module ohi_lane #(
    parameter int NODES = 4,
    parameter int AXES  = 3,
    parameter int LANE  = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ohi_pkg::q64_t       t_q,
    input  logic signed [47:0]  times [NODES],
    input  logic signed [55:0]  pos   [AXES],
    input  logic signed [47:0]  vel   [AXES],
    output logic                done,
    output ohi_pkg::q64_t       pterm [AXES],
    output ohi_pkg::q64_t       vterm [AXES]
);

    localparam int IW = $clog2(NODES);
    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

    typedef enum logic [11:0] {
        P_IDLE = 12'b0000_0000_0001,
        P_DIV  = 12'b0000_0000_0010,
        P_H    = 12'b0000_0000_0100,
        P_HD   = 12'b0000_0000_1000,
        P_HDA  = 12'b0000_0001_0000,
        P_F0   = 12'b0000_0010_0000,
        P_G1   = 12'b0000_0100_0000,
        P_G0A  = 12'b0000_1000_0000,
        P_G0B  = 12'b0001_0000_0000,
        P_HH   = 12'b0010_0000_0000,
        P_AX   = 12'b0100_0000_0000,
        P_DONE = 12'b1000_0000_0000
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [IW-1:0]   j_reg, j_next, k_reg, k_next;
    logic [2:0]      sub_reg, sub_next;
    logic [AW-1:0]   ax_reg, ax_next;
    logic            wait_reg, wait_next;

    ohi_pkg::q64_t   dt_reg, dt_next, s_reg, s_next, h_reg, h_next, hd_reg, hd_next;
    ohi_pkg::q64_t   f0_reg, f0_next, g0_reg, g0_next, g1_reg, g1_next;
    ohi_pkg::q64_t   p_reg, p_next, hh_reg, hh_next, tmp_reg, tmp_next;
    ohi_pkg::q64_t   pa_reg, pa_next, va_reg, va_next;
    ohi_pkg::q64_t   rec_reg [NODES];
    ohi_pkg::q64_t   rec_next [NODES];
    ohi_pkg::q64_t   rat_reg [NODES];
    ohi_pkg::q64_t   rat_next [NODES];
    ohi_pkg::q64_t   pterm_reg [AXES];
    ohi_pkg::q64_t   pterm_next [AXES];
    ohi_pkg::q64_t   vterm_reg [AXES];
    ohi_pkg::q64_t   vterm_next [AXES];

    ohi_pkg::q64_t   ti, tj, x, v;
    ohi_pkg::q64_t   op_a, op_b, res;
    ohi_pkg::shift_t op_sh;
    logic            use_div, skip, active, mul_start, div_start;
    logic            mul_done, div_done, unit_done;
    ohi_pkg::q64_t   mul_y, div_y;
    logic            j_last, k_last, ax_last;

    ohi_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (op_a),
        .b     (op_b),
        .sh    (op_sh),
        .done  (mul_done),
        .y     (mul_y)
    );

    ohi_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (op_a),
        .den   (op_b),
        .done  (div_done),
        .y     (div_y)
    );

    always_comb
    begin
        ti        = {{16{times[LANE][47]}}, times[LANE]};
        tj        = {{16{times[j_reg][47]}}, times[j_reg]};
        x         = {{8{pos[ax_reg][55]}}, pos[ax_reg]};
        v         = {{16{vel[ax_reg][47]}}, vel[ax_reg]};
        j_last    = (j_reg == IW'(NODES - 1));
        k_last    = (k_reg == IW'(NODES - 1));
        ax_last   = (ax_reg == AW'(AXES - 1));
        active    = (phase_reg != P_IDLE) && (phase_reg != P_DONE);
        unit_done = mul_done | div_done;
        res       = use_div ? div_y : mul_y;
    end

    // operand selection and skipped index steps
    always_comb
    begin
        op_a    = p_reg;
        op_b    = rat_reg[k_reg];
        op_sh   = ohi_pkg::SH32;
        use_div = 1'b0;
        skip    = 1'b0;
        case (phase_reg)
            P_DIV:
            begin
                use_div = 1'b1;
                skip    = (j_reg == IW'(LANE));
                op_a    = (sub_reg == 3'd0) ? ohi_pkg::q64_t'(64'sd16777216) : (t_q - tj);
                op_b    = ti - tj;
            end
            P_H:
                skip = (k_reg == IW'(LANE));
            P_HD:
                skip = (k_reg == IW'(LANE)) || (k_reg == j_reg) || (j_reg == IW'(LANE));
            P_HDA:
            begin
                skip = (j_reg == IW'(LANE));
                op_a = rec_reg[j_reg];
                op_b = p_reg;
            end
            P_F0:
            begin
                op_a  = dt_reg;
                op_b  = s_reg;
                op_sh = ohi_pkg::SH23;
            end
            P_G1:
            begin
                op_a  = dt_reg;
                op_b  = hd_reg;
                op_sh = ohi_pkg::SH23;
            end
            P_G0A:
            begin
                op_a  = f0_reg;
                op_b  = hd_reg;
                op_sh = ohi_pkg::SH31;
            end
            P_G0B:
            begin
                op_a  = h_reg;
                op_b  = s_reg;
                op_sh = ohi_pkg::SH31;
            end
            P_HH:
            begin
                op_a = h_reg;
                op_b = h_reg;
            end
            P_AX:
            begin
                case (sub_reg)
                    3'd0:
                    begin
                        op_a = x;
                        op_b = f0_reg;
                    end
                    3'd1:
                    begin
                        op_a = v;
                        op_b = dt_reg;
                    end
                    3'd2:
                    begin
                        op_a = pa_reg;
                        op_b = hh_reg;
                    end
                    3'd3:
                    begin
                        op_a  = x;
                        op_b  = g0_reg;
                        op_sh = ohi_pkg::SH24;
                    end
                    3'd4:
                    begin
                        op_a = v;
                        op_b = g1_reg;
                    end
                    default:
                    begin
                        op_a = va_reg;
                        op_b = h_reg;
                    end
                endcase
            end
            default:
            begin
                op_a = p_reg;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        sub_next   = sub_reg;
        ax_next    = ax_reg;
        wait_next  = wait_reg;
        dt_next    = dt_reg;
        s_next     = s_reg;
        h_next     = h_reg;
        hd_next    = hd_reg;
        f0_next    = f0_reg;
        g0_next    = g0_reg;
        g1_next    = g1_reg;
        p_next     = p_reg;
        hh_next    = hh_reg;
        tmp_next   = tmp_reg;
        pa_next    = pa_reg;
        va_next    = va_reg;
        rec_next   = rec_reg;
        rat_next   = rat_reg;
        pterm_next = pterm_reg;
        vterm_next = vterm_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;

        if (start)
        begin
            phase_next = P_DIV;
            j_next     = '0;
            k_next     = '0;
            sub_next   = '0;
            ax_next    = '0;
            wait_next  = 1'b0;
            s_next     = '0;
            dt_next    = t_q - ti;
        end
        else if (active && !wait_reg && !skip)
        begin
            wait_next = 1'b1;
            mul_start = !use_div;
            div_start = use_div;
        end
        else if (active && ((!wait_reg && skip) || (wait_reg && unit_done)))
        begin
            wait_next = 1'b0;
            case (phase_reg)
                P_DIV:
                begin
                    if (!skip)
                    begin
                        if (sub_reg == 3'd0)
                        begin
                            rec_next[j_reg] = res;
                            s_next          = ohi_pkg::sat_add(s_reg, res);
                        end
                        else
                            rat_next[j_reg] = res;
                    end
                    if (!skip && sub_reg == 3'd0)
                        sub_next = 3'd1;
                    else
                    begin
                        sub_next = '0;
                        if (j_last)
                        begin
                            phase_next = P_H;
                            k_next     = '0;
                            p_next     = ohi_pkg::ONE_Q32;
                        end
                        else
                            j_next = j_reg + IW'(1);
                    end
                end
                P_H:
                begin
                    if (!skip)
                        p_next = res;
                    if (k_last)
                    begin
                        h_next     = skip ? p_reg : res;
                        phase_next = P_HD;
                        j_next     = '0;
                        k_next     = '0;
                        hd_next    = '0;
                        p_next     = ohi_pkg::ONE_Q32;
                    end
                    else
                        k_next = k_reg + IW'(1);
                end
                P_HD:
                begin
                    if (!skip)
                        p_next = res;
                    if (k_last)
                    begin
                        phase_next = P_HDA;
                        k_next     = '0;
                    end
                    else
                        k_next = k_reg + IW'(1);
                end
                P_HDA:
                begin
                    if (!skip)
                        hd_next = ohi_pkg::sat_add(hd_reg, res);
                    p_next = ohi_pkg::ONE_Q32;
                    k_next = '0;
                    if (j_last)
                        phase_next = P_F0;
                    else
                    begin
                        j_next     = j_reg + IW'(1);
                        phase_next = P_HD;
                    end
                end
                P_F0:
                begin
                    f0_next    = ohi_pkg::sat_sub(ohi_pkg::ONE_Q32, res);
                    phase_next = P_G1;
                end
                P_G1:
                begin
                    g1_next    = ohi_pkg::sat_add(h_reg, res);
                    phase_next = P_G0A;
                end
                P_G0A:
                begin
                    tmp_next   = res;
                    phase_next = P_G0B;
                end
                P_G0B:
                begin
                    g0_next    = ohi_pkg::sat_sub(tmp_reg, res);
                    phase_next = P_HH;
                end
                P_HH:
                begin
                    hh_next    = res;
                    phase_next = P_AX;
                    ax_next    = '0;
                    sub_next   = '0;
                end
                P_AX:
                begin
                    sub_next = sub_reg + 3'd1;
                    case (sub_reg)
                        3'd0:    tmp_next = res;
                        3'd1:    pa_next = ohi_pkg::sat_add(tmp_reg, res);
                        3'd2:    pterm_next[ax_reg] = res;
                        3'd3:    tmp_next = res;
                        3'd4:    va_next = ohi_pkg::sat_add(tmp_reg, res);
                        default:
                        begin
                            vterm_next[ax_reg] = res;
                            sub_next           = '0;
                            if (ax_last)
                                phase_next = P_DONE;
                            else
                                ax_next = ax_reg + AW'(1);
                        end
                    endcase
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            j_reg     <= '0;
            k_reg     <= '0;
            sub_reg   <= '0;
            ax_reg    <= '0;
            wait_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            sub_reg   <= sub_next;
            ax_reg    <= ax_next;
            wait_reg  <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg    <= dt_next;
        s_reg     <= s_next;
        h_reg     <= h_next;
        hd_reg    <= hd_next;
        f0_reg    <= f0_next;
        g0_reg    <= g0_next;
        g1_reg    <= g1_next;
        p_reg     <= p_next;
        hh_reg    <= hh_next;
        tmp_reg   <= tmp_next;
        pa_reg    <= pa_next;
        va_reg    <= va_next;
        rec_reg   <= rec_next;
        rat_reg   <= rat_next;
        pterm_reg <= pterm_next;
        vterm_reg <= vterm_next;
    end

    assign done  = (phase_reg == P_DONE);
    assign pterm = pterm_reg;
    assign vterm = vterm_reg;

endmodule

### hdl/ohi_merge.sv
`timescale 1ns / 1ps
// Merge stage: saturating sums of the lane terms, one lane per cycle in node order.
// Depends on ohi_pkg.
module ohi_merge #(
    parameter int NODES = 4,
    parameter int AXES  = 3
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ohi_pkg::q64_t pterm [NODES][AXES],
    input  ohi_pkg::q64_t vterm [NODES][AXES],
    output logic          done,
    output ohi_pkg::q64_t psum  [AXES],
    output ohi_pkg::q64_t vsum  [AXES]
);

    localparam int IW = $clog2(NODES);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    ohi_pkg::q64_t psum_reg [AXES];
    ohi_pkg::q64_t vsum_reg [AXES];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + IW'(1);
            if (cnt_reg == IW'(NODES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            if (start)
            begin
                psum_reg[a] <= '0;
                vsum_reg[a] <= '0;
            end
            else if (busy_reg)
            begin
                psum_reg[a] <= ohi_pkg::sat_add(psum_reg[a], pterm[cnt_reg][a]);
                vsum_reg[a] <= ohi_pkg::sat_add(vsum_reg[a], vterm[cnt_reg][a]);
            end
        end
    end

    assign done = done_reg;
    assign psum = psum_reg;
    assign vsum = vsum_reg;

endmodule

### hdl/orbit_hermite_interpolator.sv
`timescale 1ns / 1ps
// Top level of the four-point Hermite orbit interpolator: node store, lanes, merge, output.
// Depends on ohi_pkg, ohi_lane and ohi_merge.
//
// A node load (tuser = 0) is stored and gives no result. A query (tuser = 1) runs one
// lane per node in parallel; each lane steps through its own bit-serial divider and
// bit-serial multiplier. A lane does 2*(NODES-1) divides and
// (NODES-1)*NODES + 5 + 6*AXES multiplies, and the lane terms are then merged.
// Equal node times answer with node_error set and zero values. The input side
// accepts a new item once the result is loaded into the output register, where
// that result may still wait for m_tready.
module orbit_hermite_interpolator #(
    parameter int NODES = 4,
    parameter int AXES  = 3
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // node_index[1:0], sample_time[49:2], pos_x[105:50], pos_y[161:106], pos_z[217:162],
    // vel_x[265:218], vel_y[313:266], vel_z[361:314], zero[367:362]
    input  logic [ohi_pkg::IN_TDATA_W-1:0]      s_tdata,
    // kind[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_pos_x[55:0], out_pos_y[111:56], out_pos_z[167:112],
    // out_vel_x[215:168], out_vel_y[263:216], out_vel_z[311:264]
    output logic [ohi_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // node_error[0]
    output logic                                m_tuser
);

    localparam int IW = $clog2(NODES);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_MERGE = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic               go_reg, go_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               res_err_reg, res_err_next;
    logic               merge_start;
    logic               in_acc, out_free, node_err;
    logic [NODES-1:0]   lane_done;
    logic               merge_done;

    ohi_pkg::q64_t      tq_reg;
    logic [ohi_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic [ohi_pkg::OUT_TDATA_W-1:0] out_pack;

    logic signed [47:0] t_mem   [NODES];
    logic signed [55:0] pos_mem [NODES][AXES];
    logic signed [47:0] vel_mem [NODES][AXES];

    logic [1:0]         in_idx;
    logic signed [47:0] in_time;
    logic signed [55:0] in_pos [ohi_pkg::MAX_AXES];
    logic signed [47:0] in_vel [ohi_pkg::MAX_AXES];

    ohi_pkg::q64_t      lane_p [NODES][AXES];
    ohi_pkg::q64_t      lane_v [NODES][AXES];
    ohi_pkg::q64_t      psum   [AXES];
    ohi_pkg::q64_t      vsum   [AXES];

    assign in_idx    = s_tdata[1:0];
    assign in_time   = s_tdata[49:2];
    assign in_pos[0] = s_tdata[105:50];
    assign in_pos[1] = s_tdata[161:106];
    assign in_pos[2] = s_tdata[217:162];
    assign in_vel[0] = s_tdata[265:218];
    assign in_vel[1] = s_tdata[313:266];
    assign in_vel[2] = s_tdata[361:314];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        node_err = 1'b0;
        for (int i = 0; i < NODES; i++)
            for (int j = i + 1; j < NODES; j++)
                if (t_mem[i] == t_mem[j])
                    node_err = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && !s_tuser && (int'(in_idx) < NODES))
        begin
            t_mem[IW'(in_idx)] <= in_time;
            for (int a = 0; a < AXES; a++)
            begin
                pos_mem[IW'(in_idx)][a] <= in_pos[a];
                vel_mem[IW'(in_idx)][a] <= in_vel[a];
            end
        end
        if (in_acc && s_tuser)
            tq_reg <= {{16{in_time[47]}}, in_time};
        if (state_reg == ST_OUT && out_free)
            m_tdata_reg <= res_err_reg ? '0 : out_pack;
    end

    genvar gn, ga;
    generate
        for (gn = 0; gn < NODES; gn++)
        begin : g_lane
            ohi_lane #(
                .NODES (NODES),
                .AXES  (AXES),
                .LANE  (gn)
            ) u_lane
            (
                .clk   (clk),
                .rst_n (rst_n),
                .start (go_reg),
                .t_q   (tq_reg),
                .times (t_mem),
                .pos   (pos_mem[gn]),
                .vel   (vel_mem[gn]),
                .done  (lane_done[gn]),
                .pterm (lane_p[gn]),
                .vterm (lane_v[gn])
            );
        end

        for (ga = 0; ga < ohi_pkg::MAX_AXES; ga++)
        begin : g_pack
            if (ga < AXES)
            begin : g_used
                assign out_pack[ga*56 +: 56]       = ohi_pkg::clamp_pos(psum[ga]);
                assign out_pack[168 + ga*48 +: 48] = ohi_pkg::clamp_vel(vsum[ga]);
            end
            else
            begin : g_unused
                assign out_pack[ga*56 +: 56]       = '0;
                assign out_pack[168 + ga*48 +: 48] = '0;
            end
        end
    endgenerate

    ohi_merge #(
        .NODES (NODES),
        .AXES  (AXES)
    ) u_merge
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (merge_start),
        .pterm (lane_p),
        .vterm (lane_v),
        .done  (merge_done),
        .psum  (psum),
        .vsum  (vsum)
    );

    always_comb
    begin
        state_next    = state_reg;
        go_next       = 1'b0;
        res_err_next  = res_err_reg;
        merge_start   = 1'b0;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
            m_tvalid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && s_tuser)
                begin
                    if (node_err)
                    begin
                        res_err_next = 1'b1;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        res_err_next = 1'b0;
                        go_next      = 1'b1;
                        state_next   = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (!go_reg && (&lane_done))
                begin
                    merge_start = 1'b1;
                    state_next  = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (merge_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            go_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            res_err_reg  <= 1'b0;
            m_tuser      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            go_reg       <= go_next;
            m_tvalid_reg <= m_tvalid_next;
            res_err_reg  <= res_err_next;
            if (state_reg == ST_OUT && out_free)
                m_tuser <= res_err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
